// ===== design/b2da_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
// No dependencies; imported by b2da_dabble and binary_to_decimal_ascii.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int DIGIT_BITS         = 4;

    // Upper two bits of a 6-bit ASCII digit code; the low four bits carry the digit.
    localparam logic [1:0] ASCII_DIGIT_HIGH = 2'b11;

    typedef logic [DIGIT_BITS-1:0] digit_t;

endpackage

// ===== design/b2da_dabble.sv =====
// One shift-and-add-3 step of the double dabble conversion over all BCD digits.
// Depends on b2da_pkg for the digit type and width.
`timescale 1ns / 1ps

module b2da_dabble
    import b2da_pkg::*;
#(
    parameter int NUM_DIGITS = 20
)
(
    input  logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd_in,
    input  logic                             bit_in,
    output logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd_out
);

    logic [NUM_DIGITS*DIGIT_BITS-1:0] adjusted;

    // A digit of five or more becomes ten or more after the shift, so it is
    // corrected by three beforehand to carry into the next digit.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit_t d;
            d = bcd_in[i*DIGIT_BITS +: DIGIT_BITS];
            if (d >= digit_t'(5))
            begin
                adjusted[i*DIGIT_BITS +: DIGIT_BITS] = d + digit_t'(3);
            end
            else
            begin
                adjusted[i*DIGIT_BITS +: DIGIT_BITS] = d;
            end
        end
    end

    assign bcd_out = {adjusted[NUM_DIGITS*DIGIT_BITS-2:0], bit_in};

endmodule

// ===== design/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter: sequencer and output registers.
// Depends on b2da_pkg and b2da_dabble.
`timescale 1ns / 1ps

// A number is taken when start is high while busy is low. The conversion then
// runs one binary bit per cycle through a shared double dabble step over all
// VALUE_BITS bits, followed by an emit phase over every possible decimal digit
// (20 for 64 bits) in which the digits are shifted out most significant first.
// Leading zeros are skipped silently, so a beat arrives on digit_char with
// strobe high only for digits that are part of the number; last marks the
// final digit. Busy stays high through conversion and emit, so no new number
// is taken until the last digit is shifted out. The receiver cannot stall:
// each beat is present for exactly one cycle and must be taken then.

module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  strobe,
    output logic [5:0]            digit_char,
    output logic                  last
);

    localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BcdW      = NumDigits * DIGIT_BITS;
    localparam int CntW      = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BcdW-1:0]       bcd_reg, bcd_next;
    logic                  skip_reg, skip_next;
    logic                  strobe_reg, strobe_next;
    logic [5:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [BcdW-1:0]       bcd_step;
    digit_t                top_digit;
    logic                  final_digit;
    logic                  emit;

    b2da_dabble #(
        .NUM_DIGITS(NumDigits)
    ) u_dabble (
        .bcd_in (bcd_reg),
        .bit_in (bin_reg[VALUE_BITS-1]),
        .bcd_out(bcd_step)
    );

    assign top_digit   = bcd_reg[BcdW-1 -: DIGIT_BITS];
    assign final_digit = (cnt_reg == CntW'(1));
    assign emit        = !skip_reg || (top_digit != digit_t'(0)) || final_digit;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        skip_next   = skip_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bin_next   = value;
                    bcd_next   = '0;
                    cnt_next   = CntW'(VALUE_BITS);
                    skip_next  = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_step;
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                begin
                    cnt_next   = CntW'(NumDigits);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = emit;
                char_next   = {ASCII_DIGIT_HIGH, top_digit};
                last_next   = final_digit;
                if (emit)
                begin
                    skip_next = 1'b0;
                end
                bcd_next = {bcd_reg[BcdW-DIGIT_BITS-1:0], digit_t'(0)};
                cnt_next = cnt_reg - CntW'(1);
                if (final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            skip_reg   <= 1'b1;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            skip_reg   <= skip_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

endmodule
